// ===== rtl/core/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg: shared types, constants and table function
// Holds the register map, field widths and the elaboration-time function
// that builds the quarter-wave sine table.
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int unsigned RANGE_W = 16;
   localparam int unsigned ANGLE_W = 16;
   localparam int unsigned COORD_W = 17;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_RANGE_LOW   = csr_index_type'(0);
   localparam csr_index_type CSR_RANGE_HIGH  = csr_index_type'(1);
   localparam csr_index_type CSR_START_ANGLE = csr_index_type'(2);
   localparam csr_index_type CSR_ANGLE_STEP  = csr_index_type'(3);

   localparam logic [CSR_DATA_W-1:0] RANGE_LOW_RESET   = 16'd0;
   localparam logic [CSR_DATA_W-1:0] RANGE_HIGH_RESET  = 16'd65535;
   localparam logic [CSR_DATA_W-1:0] START_ANGLE_RESET = 16'h8000;
   localparam logic [CSR_DATA_W-1:0] ANGLE_STEP_RESET  = 16'd182;

   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

   localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
   localparam int unsigned TAYLOR_TERMS = 12;
   localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   // Entry k of the quarter-wave table, sin(pi/2 * k / 2^table_bits) scaled
   // by 2^frac_bits. The series runs in Q31 with truncating steps.
   function automatic logic [63:0] sine_entry(input int unsigned table_bits,
                                              input int unsigned frac_bits,
                                              input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x = (HALF_PI_Q31 * 64'(k) + ((64'd1 << table_bits) >> 1)) >> table_bits;
      x2 = (x * x) >> 31;
      term = x;
      sum = x;
      for (int i = 0; i < TAYLOR_TERMS; i++) begin
         term = ((term * x2) >> 31) / TAYLOR_DIV[i];
         if ((i & 1) == 0) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      return ((sum << frac_bits) + (64'd1 << 30)) >> 31;
   endfunction

endpackage

// ===== rtl/core/rsc_ram.sv =====
// ----------------------------------------------------------------------------
// rsc_ram: generic dual-read memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rsc_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/core/rsc_sine_rom.sv =====
// ----------------------------------------------------------------------------
// rsc_sine_rom: quarter-wave sine lookup
// Fills the table memory after reset, then maps two binary angles onto
// table addresses and returns magnitude and sign of each sine.
// ----------------------------------------------------------------------------
module rsc_sine_rom #(
   parameter int unsigned TABLE_BITS = 10,
   parameter int unsigned SINE_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [rsc_pkg::ANGLE_W-1:0]   angle_a,
   input  logic [rsc_pkg::ANGLE_W-1:0]   angle_b,
   output logic [SINE_FRAC_BITS:0]       mag_a,
   output logic                          neg_a,
   output logic [SINE_FRAC_BITS:0]       mag_b,
   output logic                          neg_b,
   output logic                          fill_done
);

   localparam int unsigned AW = TABLE_BITS + 1;
   localparam int unsigned N = 1 << TABLE_BITS;
   localparam int unsigned DEPTH = N + 1;
   localparam int unsigned EW = SINE_FRAC_BITS + 1;

   logic [EW-1:0] sine_tab [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_tab
      assign sine_tab[k] = EW'(rsc_pkg::sine_entry(TABLE_BITS, SINE_FRAC_BITS, k));
   end

   logic [AW-1:0] fill_cnt_ff;
   logic [AW-1:0] fill_cnt_in;
   logic          fill_wr_ff;
   logic          fill_wr_in;
   logic [AW-1:0] fill_addr_ff;
   logic [AW-1:0] fill_addr_in;
   logic [EW-1:0] fill_data_ff;
   logic [EW-1:0] fill_data_in;
   logic          neg_a_ff;
   logic          neg_a_in;
   logic          neg_b_ff;
   logic          neg_b_in;
   logic [AW-1:0] addr_a;
   logic [AW-1:0] addr_b;

   function automatic logic [AW-1:0] tab_addr(input logic [rsc_pkg::ANGLE_W-1:0] angle);
      logic [14:0]   pos_rnd;
      logic [AW-1:0] idx;
      pos_rnd = {1'b0, angle[13:0]} + 15'(1 << (13 - TABLE_BITS));
      idx = pos_rnd[14 -: AW];
      return angle[14] ? AW'(N) - idx : idx;
   endfunction

   always_comb begin
      fill_cnt_in = fill_cnt_ff;
      fill_wr_in = 1'b0;
      fill_addr_in = fill_cnt_ff;
      fill_data_in = fill_data_ff;
      if (fill_cnt_ff <= AW'(N)) begin
         fill_wr_in = 1'b1;
         fill_data_in = sine_tab[fill_cnt_ff];
         fill_cnt_in = fill_cnt_ff + AW'(1);
      end
   end

   always_comb begin
      addr_a = tab_addr(angle_a);
      addr_b = tab_addr(angle_b);
      neg_a_in = rd_en ? angle_a[15] : neg_a_ff;
      neg_b_in = rd_en ? angle_b[15] : neg_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff <= '0;
         fill_wr_ff <= 1'b0;
      end else begin
         fill_cnt_ff <= fill_cnt_in;
         fill_wr_ff <= fill_wr_in;
      end
      fill_addr_ff <= fill_addr_in;
      fill_data_ff <= fill_data_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
   end

   rsc_ram #(
      .WIDTH(EW),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (fill_wr_ff),
      .wr_addr  (fill_addr_ff),
      .wr_data  (fill_data_ff),
      .rd_en    (rd_en),
      .rd_addr_a(addr_a),
      .rd_addr_b(addr_b),
      .rd_data_a(mag_a),
      .rd_data_b(mag_b)
   );

   assign neg_a = neg_a_ff;
   assign neg_b = neg_b_ff;
   assign fill_done = (fill_cnt_ff > AW'(N)) && !fill_wr_ff;

endmodule

// ===== rtl/core/rsc_scale.sv =====
// ----------------------------------------------------------------------------
// rsc_scale: range times sine
// Multiplies a range by a sine magnitude, rounds half away from zero and
// applies the sign; a rejected sample gives zero.
// ----------------------------------------------------------------------------
module rsc_scale #(
   parameter int unsigned SINE_FRAC_BITS = 15
) (
   input  logic [rsc_pkg::RANGE_W-1:0]        range_mm,
   input  logic [SINE_FRAC_BITS:0]            mag,
   input  logic                               neg,
   input  logic                               kept,
   output logic signed [rsc_pkg::COORD_W-1:0] coord
);

   localparam int unsigned PW = rsc_pkg::RANGE_W + SINE_FRAC_BITS + 1;

   logic [PW-1:0]               prod;
   logic [PW:0]                 prod_rnd;
   logic [rsc_pkg::COORD_W-1:0] mag_mm;

   assign prod = PW'(range_mm) * PW'(mag);
   assign prod_rnd = (PW + 1)'(prod) + ((PW + 1)'(1) << (SINE_FRAC_BITS - 1));
   assign mag_mm = prod_rnd[SINE_FRAC_BITS +: rsc_pkg::COORD_W];

   always_comb begin
      if (!kept) begin
         coord = '0;
      end else if (neg) begin
         coord = $signed(rsc_pkg::COORD_W'(0) - mag_mm);
      end else begin
         coord = $signed(mag_mm);
      end
   end

endmodule

// ===== rtl/core/range_scan_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// range_scan_to_cartesian: polar range scan to Cartesian points
// Turns each range sample of a rotating scan into an x/y point in
// millimetres, with range gating and per-scan angle tracking.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction, and a
// new request is taken in every cycle while the response side is not
// stalled. The sample angle is start_angle plus an offset that grows by
// angle_step per sample and returns to zero after a sample flagged
// scan_end. After reset the sine table memory is filled one entry per cycle,
// and req_ready stays low until the fill is done; register writes are
// taken during that time as always. Between a request and its response lie
// the registered read of the table memory, taken alongside the stage-one
// registers, and the multiply into the response register.
module range_scan_to_cartesian #(
   parameter int unsigned TABLE_BITS = 10,
   parameter int unsigned SINE_FRAC_BITS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rsc_pkg::RANGE_W-1:0]         req_range_mm,
   input  logic                                req_scan_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rsc_pkg::COORD_W-1:0]  rsp_x_mm,
   output logic signed [rsc_pkg::COORD_W-1:0]  rsp_y_mm,
   output logic                                rsp_kept,
   output logic                                rsp_end_of_scan,
   input  logic                                csr_wr_en,
   input  rsc_pkg::csr_index_type              csr_index,
   input  logic [rsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned EW = SINE_FRAC_BITS + 1;

   logic [rsc_pkg::CSR_DATA_W-1:0] range_low_ff;
   logic [rsc_pkg::CSR_DATA_W-1:0] range_low_in;
   logic [rsc_pkg::CSR_DATA_W-1:0] range_high_ff;
   logic [rsc_pkg::CSR_DATA_W-1:0] range_high_in;
   logic [rsc_pkg::CSR_DATA_W-1:0] start_angle_ff;
   logic [rsc_pkg::CSR_DATA_W-1:0] start_angle_in;
   logic [rsc_pkg::CSR_DATA_W-1:0] angle_step_ff;
   logic [rsc_pkg::CSR_DATA_W-1:0] angle_step_in;
   logic [rsc_pkg::ANGLE_W-1:0]    offset_ff;
   logic [rsc_pkg::ANGLE_W-1:0]    offset_in;

   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic [rsc_pkg::RANGE_W-1:0] s1_range_ff;
   logic [rsc_pkg::RANGE_W-1:0] s1_range_in;
   logic                        s1_kept_ff;
   logic                        s1_kept_in;
   logic                        s1_end_ff;
   logic                        s1_end_in;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic signed [rsc_pkg::COORD_W-1:0] rsp_x_ff;
   logic signed [rsc_pkg::COORD_W-1:0] rsp_x_in;
   logic signed [rsc_pkg::COORD_W-1:0] rsp_y_ff;
   logic signed [rsc_pkg::COORD_W-1:0] rsp_y_in;
   logic                               rsp_kept_ff;
   logic                               rsp_kept_in;
   logic                               rsp_end_ff;
   logic                               rsp_end_in;

   logic                               accept;
   logic                               out_free;
   logic                               s1_move;
   logic                               fill_done;
   logic [rsc_pkg::ANGLE_W-1:0]        cur_angle;
   logic [rsc_pkg::ANGLE_W-1:0]        cos_angle;
   logic [EW-1:0]                      cos_mag;
   logic                               cos_neg;
   logic [EW-1:0]                      sin_mag;
   logic                               sin_neg;
   logic signed [rsc_pkg::COORD_W-1:0] x_mm;
   logic signed [rsc_pkg::COORD_W-1:0] y_mm;

   always_comb begin
      range_low_in = range_low_ff;
      range_high_in = range_high_ff;
      start_angle_in = start_angle_ff;
      angle_step_in = angle_step_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rsc_pkg::CSR_RANGE_LOW:   range_low_in = csr_wdata;
            rsc_pkg::CSR_RANGE_HIGH:  range_high_in = csr_wdata;
            rsc_pkg::CSR_START_ANGLE: start_angle_in = csr_wdata;
            rsc_pkg::CSR_ANGLE_STEP:  angle_step_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_move = s1_valid_ff && out_free;
   assign req_ready = fill_done && (!s1_valid_ff || out_free);
   assign accept = req_valid && req_ready;

   assign cur_angle = start_angle_ff + offset_ff;
   assign cos_angle = cur_angle + rsc_pkg::QUARTER_TURN;

   always_comb begin
      offset_in = offset_ff;
      if (accept) begin
         offset_in = req_scan_end ? '0 : offset_ff + angle_step_ff;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_range_in = s1_range_ff;
      s1_kept_in = s1_kept_ff;
      s1_end_in = s1_end_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_range_in = req_range_mm;
         s1_kept_in = (req_range_mm > range_low_ff) && (req_range_mm < range_high_ff);
         s1_end_in = req_scan_end;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_kept_in = rsp_kept_ff;
      rsp_end_in = rsp_end_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_x_in = x_mm;
         rsp_y_in = y_mm;
         rsp_kept_in = s1_kept_ff;
         rsp_end_in = s1_end_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff <= rsc_pkg::RANGE_LOW_RESET;
         range_high_ff <= rsc_pkg::RANGE_HIGH_RESET;
         start_angle_ff <= rsc_pkg::START_ANGLE_RESET;
         angle_step_ff <= rsc_pkg::ANGLE_STEP_RESET;
         offset_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         range_low_ff <= range_low_in;
         range_high_ff <= range_high_in;
         start_angle_ff <= start_angle_in;
         angle_step_ff <= angle_step_in;
         offset_ff <= offset_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_range_ff <= s1_range_in;
      s1_kept_ff <= s1_kept_in;
      s1_end_ff <= s1_end_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_kept_ff <= rsp_kept_in;
      rsp_end_ff <= rsp_end_in;
   end

   rsc_sine_rom #(
      .TABLE_BITS    (TABLE_BITS),
      .SINE_FRAC_BITS(SINE_FRAC_BITS)
   ) u_sine_rom (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .angle_a  (cos_angle),
      .angle_b  (cur_angle),
      .mag_a    (cos_mag),
      .neg_a    (cos_neg),
      .mag_b    (sin_mag),
      .neg_b    (sin_neg),
      .fill_done(fill_done)
   );

   rsc_scale #(
      .SINE_FRAC_BITS(SINE_FRAC_BITS)
   ) u_scale_x (
      .range_mm(s1_range_ff),
      .mag     (cos_mag),
      .neg     (cos_neg),
      .kept    (s1_kept_ff),
      .coord   (x_mm)
   );

   rsc_scale #(
      .SINE_FRAC_BITS(SINE_FRAC_BITS)
   ) u_scale_y (
      .range_mm(s1_range_ff),
      .mag     (sin_mag),
      .neg     (sin_neg),
      .kept    (s1_kept_ff),
      .coord   (y_mm)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_mm = rsp_x_ff;
   assign rsp_y_mm = rsp_y_ff;
   assign rsp_kept = rsp_kept_ff;
   assign rsp_end_of_scan = rsp_end_ff;

endmodule

// ===== rtl/core/rsc_checker.sv =====
// ----------------------------------------------------------------------------
// rsc_checker: port-level checks
// Watches the ports of the converter and flags behavior that breaks its
// timing or output rules.
// ----------------------------------------------------------------------------
module rsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [rsc_pkg::COORD_W-1:0]  rsp_x_mm,
   input logic signed [rsc_pkg::COORD_W-1:0]  rsp_y_mm,
   input logic                                rsp_kept,
   input logic                                rsp_end_of_scan
);

   // A rejected sample carries a zero point.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kept |-> rsp_x_mm == '0 && rsp_y_mm == '0)
      else $error("rejected sample has a nonzero point");

   // The table fill keeps the request side closed right after reset.
   a_fill_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken before the table fill");

   // A fresh response follows an accepted transaction that passed through the stage-one and response registers.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_mm) && $stable(rsp_y_mm)
         && $stable(rsp_kept) && $stable(rsp_end_of_scan))
      else $error("stalled response changed");

endmodule

bind range_scan_to_cartesian rsc_checker u_rsc_checker (.*);

// ===== verif/range_scan_to_cartesian_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_scan_to_cartesian_test: self-checking bench for the scan converter
// Streams range samples through the block with random gaps on the request
// side and random stalls on the response side. A scoreboard tracks the
// register settings and the per-scan angle, predicts every point from its
// own sine table, and compares each response transaction field by field.
// ----------------------------------------------------------------------------
module range_scan_to_cartesian_test;

   localparam int TABLE_BITS = 10;
   localparam int SINE_FRAC_BITS = 15;
   localparam int TABLE_SIZE = 1 << TABLE_BITS;
   localparam longint unsigned RIGHT_ANGLE_Q31 = 64'd3373259426;
   localparam logic [15:0] QUARTER_TURN_BAM = 16'h4000;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES = 8;
   localparam int SAMPLES_PER_PHASE = 232;
   localparam rsc_pkg::csr_index_type CSR_UNMAPPED_FIRST = rsc_pkg::csr_index_type'(4);
   localparam rsc_pkg::csr_index_type CSR_UNMAPPED_LAST = rsc_pkg::csr_index_type'(255);

   typedef struct {
      logic signed [16:0] x_mm;
      logic signed [16:0] y_mm;
      logic kept;
      logic end_of_scan;
   } scan_point_type;

   class cartesian_scoreboard_type;
      logic [15:0] range_low;
      logic [15:0] range_high;
      logic [15:0] start_angle;
      logic [15:0] angle_step;
      logic [15:0] angle_offset;
      int sine_table [0:TABLE_SIZE];
      scan_point_type expected_points [$];
      int failures;

      function new();
         range_low = rsc_pkg::RANGE_LOW_RESET;
         range_high = rsc_pkg::RANGE_HIGH_RESET;
         start_angle = rsc_pkg::START_ANGLE_RESET;
         angle_step = rsc_pkg::ANGLE_STEP_RESET;
         angle_offset = '0;
         failures = 0;
         for (int k = 0; k <= TABLE_SIZE; k++) begin
            sine_table[k] = quarter_sine(k);
         end
      endfunction

      // Taylor series in Q31 with truncating steps, rounded to the table format.
      function int quarter_sine(int k);
         longint unsigned x;
         longint unsigned x2;
         longint unsigned term;
         longint unsigned sum;
         x = (RIGHT_ANGLE_Q31 * longint'(k) + longint'(TABLE_SIZE / 2)) >> TABLE_BITS;
         x2 = (x * x) >> 31;
         term = x;
         sum = x;
         for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 31) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         return int'(((sum << SINE_FRAC_BITS) + (64'd1 << 30)) >> 31);
      endfunction

      function int angle_sine(logic [15:0] angle);
         int unsigned idx;
         int v;
         idx = angle[13:0];
         idx = (idx + (1 << (13 - TABLE_BITS))) >> (14 - TABLE_BITS);
         if (idx > TABLE_SIZE) begin
            idx = TABLE_SIZE;
         end
         if (angle[14]) begin
            idx = TABLE_SIZE - idx;
         end
         v = sine_table[idx];
         return angle[15] ? -v : v;
      endfunction

      function logic signed [16:0] scale_coord(logic [15:0] r, int s);
         logic [63:0] mag;
         mag = 64'(r) * 64'((s < 0) ? -s : s);
         mag = (mag + (64'd1 << (SINE_FRAC_BITS - 1))) >> SINE_FRAC_BITS;
         if (s < 0) begin
            mag = -mag;
         end
         return mag[16:0];
      endfunction

      function void set_register(rsc_pkg::csr_index_type idx, logic [15:0] value);
         case (idx)
            rsc_pkg::CSR_RANGE_LOW: range_low = value;
            rsc_pkg::CSR_RANGE_HIGH: range_high = value;
            rsc_pkg::CSR_START_ANGLE: start_angle = value;
            rsc_pkg::CSR_ANGLE_STEP: angle_step = value;
            default: ;
         endcase
      endfunction

      function void note_sample(logic [15:0] r, logic last);
         scan_point_type p;
         logic [15:0] angle;
         angle = start_angle + angle_offset;
         p.kept = (r > range_low) && (r < range_high);
         p.end_of_scan = last;
         p.x_mm = '0;
         p.y_mm = '0;
         if (p.kept) begin
            p.x_mm = scale_coord(r, angle_sine(angle + QUARTER_TURN_BAM));
            p.y_mm = scale_coord(r, angle_sine(angle));
         end
         expected_points.insert(expected_points.size(), p);
         angle_offset = last ? 16'd0 : angle_offset + angle_step;
      endfunction

      function void compare_field(string field, int expected, int actual);
         if (expected != actual) begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, field, expected, actual);
         end
      endfunction

      function void check_point(logic signed [16:0] x, logic signed [16:0] y,
                                logic kept, logic end_of_scan);
         scan_point_type p;
         if (expected_points.size() == 0) begin
            failures++;
            $display("%0t: transaction expected none, got x_mm %0d y_mm %0d kept %0b end %0b",
                     $time, x, y, kept, end_of_scan);
            return;
         end
         p = expected_points.pop_front();
         compare_field("x_mm", p.x_mm, x);
         compare_field("y_mm", p.y_mm, y);
         compare_field("kept", p.kept, kept);
         compare_field("end_of_scan", p.end_of_scan, end_of_scan);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [15:0] req_range_mm;
   logic req_scan_end;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [16:0] rsp_x_mm;
   logic signed [16:0] rsp_y_mm;
   logic rsp_kept;
   logic rsp_end_of_scan;
   logic csr_wr_en;
   rsc_pkg::csr_index_type csr_index;
   logic [15:0] csr_wdata;

   cartesian_scoreboard_type board = new();
   int hold_off_cycles = 0;
   int stalled_cycles = 0;

   range_scan_to_cartesian #(
      .TABLE_BITS(TABLE_BITS),
      .SINE_FRAC_BITS(SINE_FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_range_mm(req_range_mm),
      .req_scan_end(req_scan_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_x_mm(rsp_x_mm),
      .rsp_y_mm(rsp_y_mm),
      .rsp_kept(rsp_kept),
      .rsp_end_of_scan(rsp_end_of_scan),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         board.check_point(rsp_x_mm, rsp_y_mm, rsp_kept, rsp_end_of_scan);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles = stalled_cycles + 1;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int run_left;
      bit run_ready;
      run_left = 0;
      run_ready = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_ready = !run_ready;
               if (!run_ready) begin
                  run_left = $urandom_range(1, 5);
               end else if ($urandom_range(0, 9) == 0) begin
                  run_left = $urandom_range(50, 200);
               end else begin
                  run_left = $urandom_range(1, 12);
               end
            end
            run_left--;
            rsp_ready <= run_ready;
         end
      end
   end

   task automatic write_register(input rsc_pkg::csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_register(idx, value);
   endtask

   task automatic write_limits_and_angles(input logic [15:0] low, input logic [15:0] high,
                                          input logic [15:0] start, input logic [15:0] step);
      write_register(rsc_pkg::CSR_RANGE_LOW, low);
      write_register(rsc_pkg::CSR_RANGE_HIGH, high);
      write_register(rsc_pkg::CSR_START_ANGLE, start);
      write_register(rsc_pkg::CSR_ANGLE_STEP, step);
   endtask

   task automatic send_sample(input logic [15:0] r, input logic last);
      @(negedge clock);
      req_valid <= 1'b1;
      req_range_mm <= r;
      req_scan_end <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_sample(r, last);
   endtask

   task automatic idle_gap(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic settle();
      idle_gap(1);
      while (board.expected_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_range();
      int lo;
      int hi;
      logic [15:0] r;
      lo = board.range_low;
      hi = board.range_high;
      case ($urandom_range(0, 9))
         0, 1: r = 16'($urandom);
         2: begin
            case ($urandom_range(0, 3))
               0: r = 16'h0000;
               1: r = 16'h0001;
               2: r = 16'hFFFE;
               default: r = 16'hFFFF;
            endcase
         end
         3: r = board.range_low + 16'($urandom_range(0, 2)) - 16'd1;
         4: r = board.range_high + 16'($urandom_range(0, 2)) - 16'd1;
         default: begin
            if (hi > lo + 1) begin
               r = 16'($urandom_range(lo + 1, hi - 1));
            end else begin
               r = 16'($urandom);
            end
         end
      endcase
      return r;
   endfunction

   task automatic run_directed();
      send_sample(16'd0, 1'b0);
      send_sample(16'd65535, 1'b0);
      send_sample(16'd1, 1'b0);
      send_sample(16'd65534, 1'b0);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hAAAA, 1'b1);
      send_sample(16'd65534, 1'b0);
      send_sample(16'd12345, 1'b1);
      settle();
      write_limits_and_angles(16'd0, 16'd65535, 16'h0000, QUARTER_TURN_BAM);
      repeat (4) send_sample(16'd65534, 1'b0);
      send_sample(16'd65534, 1'b1);
      settle();
      write_limits_and_angles(16'd0, 16'd65535, 16'h3FF8, 16'd8);
      repeat (3) send_sample(16'd40000, 1'b0);
      send_sample(16'd40000, 1'b1);
      settle();
      write_limits_and_angles(16'd100, 16'd200, 16'hE000, 16'h2000);
      send_sample(16'd100, 1'b0);
      send_sample(16'd101, 1'b0);
      send_sample(16'd199, 1'b0);
      send_sample(16'd200, 1'b0);
      send_sample(16'd150, 1'b0);
      send_sample(16'd65535, 1'b1);
   endtask

   task automatic configure_phase(input int phase);
      logic [15:0] low;
      logic [15:0] high;
      logic [15:0] start;
      logic [15:0] step;
      low = 16'($urandom_range(0, 4000));
      high = low + 16'($urandom_range(2, 65535 - low));
      start = 16'($urandom);
      step = 16'($urandom);
      case (phase)
         0: begin
            low = 16'd0;
            high = 16'd65535;
            start = 16'h0000;
            step = 16'd0;
         end
         1: begin
            low = 16'd65535;
            high = 16'd0;
            start = 16'h7FFF;
            step = 16'd65535;
         end
         2: begin
            low = 16'd500;
            high = 16'd501;
            start = 16'h8000;
            step = QUARTER_TURN_BAM;
         end
         3: begin
            low = 16'd1000;
            high = 16'd60000;
            step = 16'd1;
         end
         7: high = low;
         default: ;
      endcase
      if (phase == 4) begin
         write_register(CSR_UNMAPPED_FIRST, 16'($urandom));
         write_register(CSR_UNMAPPED_LAST, 16'($urandom));
      end
      write_limits_and_angles(low, high, start, step);
   endtask

   task automatic run_scans(input int count, input bit long_hold, input bit midway_drain);
      int scan_len;
      int scan_pos;
      int burst_left;
      logic [15:0] r;
      logic last;
      scan_len = 1;
      scan_pos = 0;
      burst_left = $urandom_range(1, 40);
      if (long_hold) begin
         hold_off_cycles = LONG_HOLD_CYCLES;
      end
      for (int i = 0; i < count; i++) begin
         if (midway_drain && i == count / 2) begin
            settle();
         end
         if (burst_left == 0) begin
            idle_gap($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                    : $urandom_range(1, 40);
         end
         burst_left--;
         if (scan_pos == 0) begin
            scan_len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 360)
                                                  : $urandom_range(1, 40);
         end
         r = pick_range();
         last = (scan_pos == scan_len - 1) || ($urandom_range(0, 39) == 0);
         send_sample(r, last);
         scan_pos = last ? 0 : scan_pos + 1;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_range_mm = '0;
      req_scan_end = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = rsc_pkg::CSR_RANGE_LOW;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         configure_phase(phase);
         run_scans(SAMPLES_PER_PHASE, phase == 3, phase == 5);
      end
      settle();
      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.expected_points.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== range_scan_to_cartesian.f =====
rtl/core/rsc_pkg.sv
rtl/core/rsc_ram.sv
rtl/core/rsc_sine_rom.sv
rtl/core/rsc_scale.sv
rtl/core/range_scan_to_cartesian.sv
rtl/core/rsc_checker.sv
verif/range_scan_to_cartesian_test.sv
